/* hdl/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier: machine phases,
// event codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TIME_WIDTH_DEFAULT = 32;
  localparam int unsigned NOW_WIDTH          = 32;
  localparam int unsigned MS_WIDTH           = 32;
  localparam int unsigned CFG_INDEX_WIDTH    = 3;
  localparam int unsigned CFG_DATA_WIDTH     = 32;
  localparam int unsigned COUNT_WIDTH        = 8;

  localparam logic [MS_WIDTH-1:0] DEBOUNCE_RESET   = MS_WIDTH'(50);
  localparam logic [MS_WIDTH-1:0] LONG_PRESS_RESET = MS_WIDTH'(1000);
  localparam logic [MS_WIDTH-1:0] CLICK_GAP_RESET  = MS_WIDTH'(400);

  // Two clicks resolve the count phase at once.
  localparam logic [COUNT_WIDTH-1:0] DOUBLE_COUNT = COUNT_WIDTH'(2);
  localparam logic [COUNT_WIDTH-1:0] SINGLE_COUNT = COUNT_WIDTH'(1);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_LONG_PRESS   = 3'd1,
    CFG_CLICK_GAP    = 3'd2,
    CFG_CLICK_EN     = 3'd3,
    CFG_DOUBLE_EN    = 3'd4,
    CFG_LONG_START   = 3'd5,
    CFG_LONG_RELEASE = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DOWN     = 3'd1,
    PH_UP       = 3'd2,
    PH_COUNT    = 3'd3,
    PH_HELD     = 3'd4,
    PH_RELEASED = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CLICK        = 3'd1,
    EV_DOUBLE       = 3'd2,
    EV_LONG_START   = 3'd3,
    EV_LONG_RELEASE = 3'd4
  } event_t;

  typedef struct packed {
    logic click;
    logic double_click;
    logic long_start;
    logic long_release;
  } enable_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   stable_level;
    logic                   last_raw_level;
    logic [COUNT_WIDTH-1:0] click_count;
  } ctrl_t;

  typedef struct packed {
    event_t ev;
    logic   level;
  } result_t;

endpackage

/* hdl/bcc_step.sv */
// ----------------------------------------------------------------------------
// bcc_step
// Next-state and event logic for one poll: debounce of the raw level, then
// one step of the click / double click / long press machine.
// ----------------------------------------------------------------------------
module bcc_step
  import bcc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic                  raw_level,
  input  logic [TIME_WIDTH-1:0] now,
  input  ctrl_t                 ctrl,
  input  logic [TIME_WIDTH-1:0] last_change_time,
  input  logic [TIME_WIDTH-1:0] phase_start_time,
  input  logic [MS_WIDTH-1:0]   debounce_ms,
  input  logic [MS_WIDTH-1:0]   long_press_ms,
  input  logic [MS_WIDTH-1:0]   click_gap_ms,
  input  enable_t               enable,
  output ctrl_t                 ctrl_next,
  output logic [TIME_WIDTH-1:0] last_change_time_next,
  output logic [TIME_WIDTH-1:0] phase_start_time_next,
  output result_t               result
);

  // Compare width wide enough for both a time difference and a 32-bit limit.
  localparam int unsigned CW = (TIME_WIDTH > MS_WIDTH) ? TIME_WIDTH : MS_WIDTH;

  logic [TIME_WIDTH-1:0] since_change;
  logic [TIME_WIDTH-1:0] wait_time;
  logic                  level;
  logic                  settled;
  logic                  long_due;
  logic                  gap_due;
  logic                  soft_reset;
  event_t                ev;

  assign since_change = now - last_change_time;
  assign wait_time    = now - phase_start_time;
  assign settled      = CW'(since_change) >= CW'(debounce_ms);
  assign long_due     = CW'(wait_time) > CW'(long_press_ms);
  assign gap_due      = CW'(wait_time) >= CW'(click_gap_ms);

  always_comb begin
    ctrl_next             = ctrl;
    last_change_time_next = last_change_time;
    phase_start_time_next = phase_start_time;
    ev                    = EV_NONE;
    soft_reset            = 1'b0;

    // Debounce: a changed level restarts the hold timer.
    if (ctrl.last_raw_level == raw_level) begin
      if (settled) begin
        ctrl_next.stable_level = raw_level;
      end
    end else begin
      last_change_time_next    = now;
      ctrl_next.last_raw_level = raw_level;
    end
    level = ctrl_next.stable_level;

    case (ctrl.phase)
      PH_IDLE: begin
        if (level) begin
          ctrl_next.phase       = PH_DOWN;
          phase_start_time_next = now;
          ctrl_next.click_count = '0;
        end
      end
      PH_DOWN: begin
        if (!level) begin
          ctrl_next.phase       = PH_UP;
          phase_start_time_next = now;
        end else if (long_due && enable.long_start) begin
          ev              = EV_LONG_START;
          ctrl_next.phase = PH_HELD;
        end
      end
      PH_UP: begin
        ctrl_next.click_count = ctrl.click_count + COUNT_WIDTH'(1);
        ctrl_next.phase       = PH_COUNT;
      end
      PH_COUNT: begin
        if (level) begin
          ctrl_next.phase       = PH_DOWN;
          phase_start_time_next = now;
        end else if (gap_due || ctrl.click_count == DOUBLE_COUNT) begin
          if (ctrl.click_count == SINGLE_COUNT && enable.click) begin
            ev = EV_CLICK;
          end else if (ctrl.click_count == DOUBLE_COUNT && enable.double_click) begin
            ev = EV_DOUBLE;
          end
          soft_reset = 1'b1;
        end
      end
      PH_HELD: begin
        if (!level) begin
          ctrl_next.phase       = PH_RELEASED;
          phase_start_time_next = now;
        end
      end
      PH_RELEASED: begin
        if (enable.long_release) begin
          ev = EV_LONG_RELEASE;
        end
        soft_reset = 1'b1;
      end
      default: begin
        ctrl_next.phase = PH_IDLE;
      end
    endcase

    // The hold timer's start time survives a soft reset.
    if (soft_reset) begin
      ctrl_next.phase          = PH_IDLE;
      ctrl_next.click_count    = '0;
      ctrl_next.stable_level   = 1'b0;
      ctrl_next.last_raw_level = 1'b0;
      phase_start_time_next    = '0;
    end

    result.ev    = ev;
    result.level = level;
  end

endmodule

/* hdl/bcc_out_buf.sv */
// ----------------------------------------------------------------------------
// bcc_out_buf
// Two-entry result buffer: an output register backed by a skid register, so
// a new result can be taken while the previous one waits for transfer.
// ----------------------------------------------------------------------------
module bcc_out_buf
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    head_free;

  assign can_push  = !skid_valid;
  assign head_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("pending result changed before transfer");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> out_valid && out_data == $past(skid_data))
    else $error("skid entry lost or reordered");

endmodule

/* hdl/button_click_classifier_core.sv */
// ----------------------------------------------------------------------------
// button_click_classifier_core
// Debounced push-button classifier reporting click, double click, long press
// start and long press release, one result per poll.
// ----------------------------------------------------------------------------
// Each accepted poll (raw level plus millisecond time) is processed in the
// cycle it is accepted: the debounce and phase logic update the state
// registers at that edge and the result is registered in the output buffer.
// A poll can be accepted every cycle that in_ready is high. Results wait in a
// two-entry output buffer, so in_ready drops only when two results are waiting
// for transfer. Configuration writes are always taken (cfg_ready is tied
// high); writes to an index beyond the register list are ignored. Times are
// kept at TIME_WIDTH bits and all differences wrap at that width.
module button_click_classifier_core
  import bcc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       raw_level,
  input  logic [NOW_WIDTH-1:0]       now_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 event_res,
  output logic                       clean_level
);

  localparam int unsigned NW = (TIME_WIDTH < NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;

  logic [MS_WIDTH-1:0]   debounce_ms;
  logic [MS_WIDTH-1:0]   long_press_ms;
  logic [MS_WIDTH-1:0]   click_gap_ms;
  enable_t               enable;

  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [TIME_WIDTH-1:0] last_change_time;
  logic [TIME_WIDTH-1:0] last_change_time_next;
  logic [TIME_WIDTH-1:0] phase_start_time;
  logic [TIME_WIDTH-1:0] phase_start_time_next;
  logic [TIME_WIDTH-1:0] now;
  result_t               step_result;
  result_t               out_data;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign now       = TIME_WIDTH'(now_ms[NW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      long_press_ms <= LONG_PRESS_RESET;
      click_gap_ms  <= CLICK_GAP_RESET;
      enable        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:     debounce_ms         <= cfg_data[MS_WIDTH-1:0];
        CFG_LONG_PRESS:   long_press_ms       <= cfg_data[MS_WIDTH-1:0];
        CFG_CLICK_GAP:    click_gap_ms        <= cfg_data[MS_WIDTH-1:0];
        CFG_CLICK_EN:     enable.click        <= cfg_data[0];
        CFG_DOUBLE_EN:    enable.double_click <= cfg_data[0];
        CFG_LONG_START:   enable.long_start   <= cfg_data[0];
        CFG_LONG_RELEASE: enable.long_release <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bcc_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .raw_level             (raw_level),
    .now                   (now),
    .ctrl                  (ctrl),
    .last_change_time      (last_change_time),
    .phase_start_time      (phase_start_time),
    .debounce_ms           (debounce_ms),
    .long_press_ms         (long_press_ms),
    .click_gap_ms          (click_gap_ms),
    .enable                (enable),
    .ctrl_next             (ctrl_next),
    .last_change_time_next (last_change_time_next),
    .phase_start_time_next (phase_start_time_next),
    .result                (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl             <= '{phase: PH_IDLE, default: '0};
      last_change_time <= '0;
      phase_start_time <= '0;
    end else if (accept) begin
      ctrl             <= ctrl_next;
      last_change_time <= last_change_time_next;
      phase_start_time <= phase_start_time_next;
    end
  end

  bcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign event_res   = out_data.ev;
  assign clean_level = out_data.level;

  a_long_start_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && step_result.ev == EV_LONG_START) |=> ctrl.phase == PH_HELD)
    else $error("long press start without entering held phase");

  a_up_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && ctrl.phase == PH_UP) |=>
      ctrl.phase == PH_COUNT && ctrl.click_count == $past(ctrl.click_count) + 8'd1)
    else $error("release did not advance the click count");

  a_click_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && (step_result.ev == EV_CLICK || step_result.ev == EV_DOUBLE)) |=>
      ctrl.phase == PH_IDLE && ctrl.click_count == '0 && !ctrl.stable_level)
    else $error("click report did not return the machine to idle");

endmodule

/* test/button_click_classifier_core_tb.sv */
// ----------------------------------------------------------------------------
// button_click_classifier_core_tb
// Self-checking testbench for the button click classifier. A scoreboard keeps
// its own copy of the debounce and click state, predicts the event and clean
// level of every accepted poll, and compares them with each output transfer.
// Stimulus is a short directed run followed by randomized press gestures with
// bounce and noise, under several register settings and handshake idle mixes.
// ----------------------------------------------------------------------------
module button_click_classifier_core_tb
  import bcc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;

  class button_event_scoreboard;
    logic [MS_WIDTH-1:0]    debounce_ms;
    logic [MS_WIDTH-1:0]    long_press_ms;
    logic [MS_WIDTH-1:0]    click_gap_ms;
    enable_t                enables;
    phase_t                 phase;
    logic                   stable_level;
    logic                   last_raw;
    logic [NOW_WIDTH-1:0]   last_change_ms;
    logic [NOW_WIDTH-1:0]   phase_start_ms;
    logic [COUNT_WIDTH-1:0] click_count;
    result_t                expected_results[$];
    int                     mismatches;

    function new();
      debounce_ms    = DEBOUNCE_RESET;
      long_press_ms  = LONG_PRESS_RESET;
      click_gap_ms   = CLICK_GAP_RESET;
      enables        = '0;
      last_change_ms = '0;
      mismatches     = 0;
      clear_to_idle();
    endfunction

    // The change timestamp survives a return to idle.
    function void clear_to_idle();
      phase          = PH_IDLE;
      phase_start_ms = '0;
      click_count    = '0;
      stable_level   = 1'b0;
      last_raw       = 1'b0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        CFG_DEBOUNCE:     debounce_ms          = data;
        CFG_LONG_PRESS:   long_press_ms        = data;
        CFG_CLICK_GAP:    click_gap_ms         = data;
        CFG_CLICK_EN:     enables.click        = data[0];
        CFG_DOUBLE_EN:    enables.double_click = data[0];
        CFG_LONG_START:   enables.long_start   = data[0];
        CFG_LONG_RELEASE: enables.long_release = data[0];
        default: ;
      endcase
    endfunction

    function void note_poll(logic raw, logic [NOW_WIDTH-1:0] now);
      logic [NOW_WIDTH-1:0] held_ms;
      event_t               ev;
      logic                 level;
      result_t              res;
      ev = EV_NONE;
      if (last_raw == raw) begin
        if (now - last_change_ms >= debounce_ms) stable_level = raw;
      end else begin
        last_change_ms = now;
        last_raw       = raw;
      end
      level   = stable_level;
      held_ms = now - phase_start_ms;
      case (phase)
        PH_IDLE: begin
          if (level) begin
            phase          = PH_DOWN;
            phase_start_ms = now;
            click_count    = '0;
          end
        end
        PH_DOWN: begin
          if (!level) begin
            phase          = PH_UP;
            phase_start_ms = now;
          end else if (held_ms > long_press_ms && enables.long_start) begin
            ev    = EV_LONG_START;
            phase = PH_HELD;
          end
        end
        PH_UP: begin
          click_count = click_count + 1'b1;
          phase       = PH_COUNT;
        end
        PH_COUNT: begin
          if (level) begin
            phase          = PH_DOWN;
            phase_start_ms = now;
          end else if (held_ms >= click_gap_ms || click_count == DOUBLE_COUNT) begin
            if (click_count == SINGLE_COUNT && enables.click) ev = EV_CLICK;
            else if (click_count == DOUBLE_COUNT && enables.double_click) ev = EV_DOUBLE;
            clear_to_idle();
          end
        end
        PH_HELD: begin
          if (!level) begin
            phase          = PH_RELEASED;
            phase_start_ms = now;
          end
        end
        PH_RELEASED: begin
          if (enables.long_release) ev = EV_LONG_RELEASE;
          clear_to_idle();
        end
        default: phase = PH_IDLE;
      endcase
      res.ev    = ev;
      res.level = level;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [2:0] ev, logic level);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual event %0d level %b",
                 $time, ev, level);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (ev !== want.ev) begin
        $display("%0t: event_res mismatch: expected %0d, actual %0d", $time, want.ev, ev);
        mismatches++;
      end
      if (level !== want.level) begin
        $display("%0t: clean_level mismatch: expected %b, actual %b",
                 $time, want.level, level);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       raw_level = 1'b0;
  logic [NOW_WIDTH-1:0]       now_ms = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 event_res;
  logic                       clean_level;

  button_event_scoreboard sb = new();

  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   polls_sent = 0;
  int                   phase_target = 0;
  int                   cycle_count = 0;
  logic [NOW_WIDTH-1:0] clock_ms = '0;
  logic [MS_WIDTH-1:0]  cfg_deb, cfg_long, cfg_gap;

  button_click_classifier_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_level  (raw_level),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .clean_level(clean_level)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every transfer is seen with the values that stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_poll(raw_level, now_ms);
      if (out_valid && out_ready) sb.check_result(event_res, clean_level);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [MS_WIDTH-1:0] jitter_ms(logic [MS_WIDTH-1:0] base,
                                                    logic [MS_WIDTH-1:0] extra);
    return base + $urandom_range(0, extra);
  endfunction

  task automatic send_poll(logic raw, logic [NOW_WIDTH-1:0] now);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid  <= 1'b1;
    raw_level <= raw;
    now_ms    <= now;
    do @(posedge clk); while (!in_ready);
    polls_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_config(logic [MS_WIDTH-1:0] deb, logic [MS_WIDTH-1:0] lp,
                              logic [MS_WIDTH-1:0] gap, enable_t en);
    logic [CFG_DATA_WIDTH-1:0] filler;
    drain_results();
    repeat (3) @(posedge clk);
    filler = $urandom();
    put_reg(CFG_DEBOUNCE, deb);
    put_reg(CFG_LONG_PRESS, lp);
    put_reg(CFG_CLICK_GAP, gap);
    // Only bit 0 of an enable register matters; the rest carry noise.
    put_reg(CFG_CLICK_EN, {filler[31:1], en.click});
    put_reg(CFG_DOUBLE_EN, {~filler[31:1], en.double_click});
    put_reg(CFG_LONG_START, {filler[31:1], en.long_start});
    put_reg(CFG_LONG_RELEASE, {~filler[31:1], en.long_release});
    cfg_valid <= 1'b0;
    cfg_deb  = deb;
    cfg_long = lp;
    cfg_gap  = gap;
  endtask

  // Polls are spaced at one ms each; the pattern is read from its top bit down.
  task automatic play_pattern(logic [15:0] bits, int n, logic [NOW_WIDTH-1:0] t0);
    for (int i = n - 1; i >= 0; i--) send_poll(bits[i], t0 + (n - 1 - i));
  endtask

  // Holds one level for about dur_ms, sometimes after a short contact bounce.
  task automatic hold_level(logic level, logic [MS_WIDTH-1:0] dur_ms);
    longint              elapsed;
    logic [MS_WIDTH-1:0] step;
    elapsed = 0;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_poll(!level, clock_ms);
        clock_ms++;
      end
    end
    do begin
      send_poll(level, clock_ms);
      step = 1 + $urandom_range(0, dur_ms / 6);
      clock_ms += step;
      elapsed += step;
    end while (elapsed < longint'(dur_ms));
  endtask

  task automatic gesture();
    int kind;
    int presses;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0:       clock_ms = $urandom();
          1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
          default: clock_ms += $urandom_range(0, 3);
        endcase
        send_poll(1'($urandom_range(0, 1)), clock_ms);
      end
    end else if (kind < 75) begin
      // One to four presses, mostly one or two.
      presses = (kind < 40) ? 1 : (kind < 65) ? 2 : $urandom_range(3, 4);
      repeat (presses) begin
        hold_level(1'b1, jitter_ms(cfg_deb + 1, cfg_long / 3));
        hold_level(1'b0, jitter_ms(cfg_deb + 1, cfg_gap / 2));
      end
      hold_level(1'b0, jitter_ms(cfg_deb + cfg_gap, cfg_gap));
    end else begin
      hold_level(1'b1, jitter_ms(cfg_deb + cfg_long + 1, cfg_long / 2));
      hold_level(1'b0, jitter_ms(cfg_deb + cfg_gap, cfg_gap));
    end
    if ($urandom_range(0, 29) == 0) drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Zero times with only long start enabled: a long press across the time
    // wrap, then a release that is reported as nothing.
    apply_config('0, '0, '0, enable_t'(4'b0010));
    play_pattern(16'b0111000, 7, 32'hFFFF_FFFE);

    // Long press out of reach: a double click resolved at once, then a click.
    apply_config('0, 32'hFFFF_FFFF, '0, enable_t'(4'b1111));
    play_pattern(16'b1100110000110000, 16, 32'h8000_0000);

    clock_ms = 32'hFFFF_F000;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          apply_config($urandom_range(0, 10), $urandom_range(20, 120),
                       $urandom_range(10, 60), enable_t'(4'b1111));
        end
        1: begin
          idle_pct  = 72;
          stall_pct = 0;
          apply_config($urandom_range(0, 20), $urandom_range(10, 300),
                       $urandom_range(5, 150), enable_t'(4'($urandom_range(0, 15))));
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 72;
          apply_config(DEBOUNCE_RESET, LONG_PRESS_RESET, CLICK_GAP_RESET,
                       enable_t'(4'b1111));
        end
        3: begin
          idle_pct  = 24;
          stall_pct = 24;
          // Long start off keeps a held button in the down phase.
          apply_config($urandom_range(0, 10), $urandom_range(10, 100),
                       $urandom_range(5, 80),
                       enable_t'(4'($urandom_range(0, 15)) & 4'b1101));
        end
        4: begin
          idle_pct  = 0;
          stall_pct = 0;
          apply_config('0, '0, '0, enable_t'(4'b1111));
        end
        default: begin
          idle_pct  = 24;
          stall_pct = 24;
          apply_config($urandom_range(0, 5), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       enable_t'(4'($urandom_range(0, 15))));
        end
      endcase
      phase_target = polls_sent + 105;
      while (polls_sent < phase_target) gesture();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 sb.expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
